[hdl/ledimc_pkg.sv]
// Shared types, codes and constants for the LED indicator mode controller.
`default_nettype none
package ledimc_pkg;

    // LED count and widths that follow from the fixed field widths
    localparam int LED_COUNT = 5;
    localparam int LED_W     = 5;
    localparam int IDX_W     = 3;
    localparam int TIME_W    = 32;
    localparam int IVL_W     = 16;
    localparam int CODE_W    = 8;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    // Reset values of the configuration registers
    localparam logic [IVL_W-1:0]  SLOW_BLINK_RST   = 16'd300;
    localparam logic [IVL_W-1:0]  FAST_STEP_RST    = 16'd250;
    localparam logic [IVL_W-1:0]  SELECT_WIN_RST   = 16'd3000;
    localparam logic [CODE_W-1:0] CODE_LEFT_RST    = 8'd71;
    localparam logic [CODE_W-1:0] CODE_TOGGLE_RST  = 8'd72;
    localparam logic [CODE_W-1:0] CODE_RIGHT_RST   = 8'd73;

    // Rider step after the last LED: one blank step, then restart
    localparam logic [IDX_W-1:0] RIDER_LAST  = IDX_W'(LED_COUNT + 1);
    localparam logic [IDX_W-1:0] RIDER_RST   = 3'd1;
    localparam logic [IDX_W-1:0] LED_TOP_IDX = IDX_W'(LED_COUNT - 1);
    localparam logic [LED_W-1:0] LED_ALL     = LED_W'((1 << LED_COUNT) - 1);

    // Input word kinds
    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_REMOTE = 2'd1,
        KIND_BUTTON = 2'd2,
        KIND_MODE   = 2'd3
    } kind_t;

    // LED modes
    typedef enum logic [2:0] {
        MODE_OFF      = 3'd0,
        MODE_ON       = 3'd1,
        MODE_BLINK    = 3'd2,
        MODE_RIDER    = 3'd3,
        MODE_STATEFUL = 3'd4
    } mode_t;

    // Configuration register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_SLOW_BLINK  = 3'd0,
        REG_FAST_STEP   = 3'd1,
        REG_SELECT_WIN  = 3'd2,
        REG_CODE_LEFT   = 3'd3,
        REG_CODE_TOGGLE = 3'd4,
        REG_CODE_RIGHT  = 3'd5
    } reg_idx_t;

endpackage
`default_nettype wire

[hdl/led_indicator_mode_controller.sv]
// LED indicator mode controller: input register, one-pass update, result register.
//
// Usage: each word on the s_ channel is one event: a 1 ms tick, a remote
// command code, a profile button press or a mode select. Every accepted word
// yields exactly one word on the m_ channel with the LED levels and the
// profile bits after that event.
// Flow: a word accepted into the input register is processed into the result
// register once that register is free, and is shown on m_valid from then on.
// Throughput: one word per cycle. The whole state update is a few 32-bit
// subtract-and-compare paths between the input register and the result
// register, so the pipeline advances every cycle the receiver takes words.
// Stall: when m_ready is low the result register holds; the input register
// still takes one more word, then s_ready drops until the result is taken.
// Reset (aresetn low, synchronous): the time count, stored times, selection,
// profile bits and LEDs clear, the rider step goes to one, the mode goes to
// all off and the configuration registers return to their defaults.
// Configuration: APB-style writes at byte address 4*index, pready always high;
// write only while no word is in flight.
`default_nettype none
module led_indicator_mode_controller (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input channel
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [1:0]                      s_kind,
    input  wire logic [7:0]                      s_remote_code,
    input  wire logic [2:0]                      s_button_index,
    input  wire logic [2:0]                      s_new_mode,
    // result channel
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [4:0]                           m_led_levels,
    output logic [4:0]                           m_profile_bits,
    // configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [ledimc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [ledimc_pkg::DATA_W-1:0]   pwdata,
    output logic [ledimc_pkg::DATA_W-1:0]        prdata,
    output logic                                 pready
);

    // configuration registers
    logic [ledimc_pkg::IVL_W-1:0]  slow_blink_reg;
    logic [ledimc_pkg::IVL_W-1:0]  fast_step_reg;
    logic [ledimc_pkg::IVL_W-1:0]  select_win_reg;
    logic [ledimc_pkg::CODE_W-1:0] code_left_reg;
    logic [ledimc_pkg::CODE_W-1:0] code_toggle_reg;
    logic [ledimc_pkg::CODE_W-1:0] code_right_reg;
    ledimc_pkg::reg_idx_t          cfg_idx;
    logic                          cfg_write;

    // input register
    logic                          in_valid_reg;
    ledimc_pkg::kind_t             kind_reg;
    logic [7:0]                    code_reg;
    logic [2:0]                    button_reg;
    logic [2:0]                    new_mode_reg;

    // block state
    logic [ledimc_pkg::TIME_W-1:0] now_reg,        now_next;
    logic [ledimc_pkg::TIME_W-1:0] led_time_reg,   led_time_next;
    logic [ledimc_pkg::TIME_W-1:0] sel_time_reg,   sel_time_next;
    logic [ledimc_pkg::IDX_W-1:0]  rider_reg,      rider_next;
    logic [ledimc_pkg::IDX_W-1:0]  sel_idx_reg,    sel_idx_next;
    logic [ledimc_pkg::LED_W-1:0]  profile_reg,    profile_next;
    logic [ledimc_pkg::LED_W-1:0]  led_reg,        led_next;
    ledimc_pkg::mode_t             mode_reg,       mode_next;

    // result register
    logic                          out_valid_reg;
    logic [ledimc_pkg::LED_W-1:0]  out_led_reg;
    logic [ledimc_pkg::LED_W-1:0]  out_profile_reg;

    logic                          advance;
    logic [ledimc_pkg::TIME_W-1:0] led_age;
    logic [ledimc_pkg::TIME_W-1:0] sel_age;
    logic [ledimc_pkg::LED_W-1:0]  sel_bit;
    logic [ledimc_pkg::LED_W-1:0]  base_led;

    // Handshake: process the held word whenever the result register frees up
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_led_levels   = out_led_reg;
    assign m_profile_bits = out_profile_reg;

    // Configuration port decode
    assign pready    = 1'b1;
    assign cfg_idx   = ledimc_pkg::reg_idx_t'(paddr[4:2]);
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        case (cfg_idx)
            ledimc_pkg::REG_SLOW_BLINK:  prdata = ledimc_pkg::DATA_W'(slow_blink_reg);
            ledimc_pkg::REG_FAST_STEP:   prdata = ledimc_pkg::DATA_W'(fast_step_reg);
            ledimc_pkg::REG_SELECT_WIN:  prdata = ledimc_pkg::DATA_W'(select_win_reg);
            ledimc_pkg::REG_CODE_LEFT:   prdata = ledimc_pkg::DATA_W'(code_left_reg);
            ledimc_pkg::REG_CODE_TOGGLE: prdata = ledimc_pkg::DATA_W'(code_toggle_reg);
            ledimc_pkg::REG_CODE_RIGHT:  prdata = ledimc_pkg::DATA_W'(code_right_reg);
            default:                     prdata = '0;
        endcase
    end

    // Write configuration registers; unlisted indexes drop the write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slow_blink_reg  <= ledimc_pkg::SLOW_BLINK_RST;
            fast_step_reg   <= ledimc_pkg::FAST_STEP_RST;
            select_win_reg  <= ledimc_pkg::SELECT_WIN_RST;
            code_left_reg   <= ledimc_pkg::CODE_LEFT_RST;
            code_toggle_reg <= ledimc_pkg::CODE_TOGGLE_RST;
            code_right_reg  <= ledimc_pkg::CODE_RIGHT_RST;
        end else if (cfg_write) begin
            case (cfg_idx)
                ledimc_pkg::REG_SLOW_BLINK:  slow_blink_reg  <= pwdata[15:0];
                ledimc_pkg::REG_FAST_STEP:   fast_step_reg   <= pwdata[15:0];
                ledimc_pkg::REG_SELECT_WIN:  select_win_reg  <= pwdata[15:0];
                ledimc_pkg::REG_CODE_LEFT:   code_left_reg   <= pwdata[7:0];
                ledimc_pkg::REG_CODE_TOGGLE: code_toggle_reg <= pwdata[7:0];
                ledimc_pkg::REG_CODE_RIGHT:  code_right_reg  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Capture the incoming word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            kind_reg     <= ledimc_pkg::kind_t'(s_kind);
            code_reg     <= s_remote_code;
            button_reg   <= s_button_index;
            new_mode_reg <= s_new_mode;
        end
    end

    // Apply the event, then run the LED update at the new time
    always_comb begin
        now_next      = now_reg;
        led_time_next = led_time_reg;
        sel_time_next = sel_time_reg;
        rider_next    = rider_reg;
        sel_idx_next  = sel_idx_reg;
        profile_next  = profile_reg;
        led_next      = led_reg;
        mode_next     = mode_reg;

        // event
        case (kind_reg)
            ledimc_pkg::KIND_TICK: begin
                now_next = now_reg + 1'b1;
            end
            ledimc_pkg::KIND_REMOTE: begin
                // left wins over toggle, toggle over right
                if (code_reg == code_left_reg) begin
                    sel_idx_next  = (sel_idx_reg == '0) ? ledimc_pkg::LED_TOP_IDX
                                                        : sel_idx_reg - 1'b1;
                    sel_time_next = now_reg;
                end else if (code_reg == code_toggle_reg) begin
                    profile_next  = profile_reg ^ (ledimc_pkg::LED_W'(1) << sel_idx_reg);
                    sel_time_next = '0;
                end else if (code_reg == code_right_reg) begin
                    sel_idx_next  = (sel_idx_reg >= ledimc_pkg::LED_TOP_IDX) ? '0
                                                        : sel_idx_reg + 1'b1;
                    sel_time_next = now_reg;
                end
            end
            ledimc_pkg::KIND_BUTTON: begin
                if (button_reg < ledimc_pkg::IDX_W'(ledimc_pkg::LED_COUNT)) begin
                    profile_next = profile_reg ^ (ledimc_pkg::LED_W'(1) << button_reg);
                end
            end
            ledimc_pkg::KIND_MODE: begin
                if (new_mode_reg <= ledimc_pkg::MODE_STATEFUL) begin
                    mode_next = ledimc_pkg::mode_t'(new_mode_reg);
                end
            end
            default: ;
        endcase

        // LED update
        led_age  = now_next - led_time_next;
        sel_age  = now_next - sel_time_next;
        sel_bit  = ledimc_pkg::LED_W'(1) << sel_idx_next;
        base_led = (led_reg & sel_bit) | (profile_next & ~sel_bit);

        case (mode_next)
            ledimc_pkg::MODE_OFF: begin
                led_next = '0;
            end
            ledimc_pkg::MODE_ON: begin
                led_next = ledimc_pkg::LED_ALL;
            end
            ledimc_pkg::MODE_BLINK: begin
                if (led_age > ledimc_pkg::TIME_W'(slow_blink_reg)) begin
                    led_time_next = now_next;
                    led_next      = ~led_reg & ledimc_pkg::LED_ALL;
                end
            end
            ledimc_pkg::MODE_RIDER: begin
                if (led_age > ledimc_pkg::TIME_W'(fast_step_reg)) begin
                    led_time_next = now_next;
                    if (rider_reg < ledimc_pkg::IDX_W'(ledimc_pkg::LED_COUNT)) begin
                        led_next = led_reg | (ledimc_pkg::LED_W'(1) << rider_reg);
                    end
                    rider_next = rider_reg + 1'b1;
                    // blank step done: restart from the first LED
                    if (rider_next == ledimc_pkg::RIDER_LAST) begin
                        rider_next = '0;
                        led_next   = '0;
                    end
                end
            end
            ledimc_pkg::MODE_STATEFUL: begin
                led_next = base_led;
                if (sel_age < ledimc_pkg::TIME_W'(select_win_reg)) begin
                    // blink the selected LED inside the window
                    if (led_age > ledimc_pkg::TIME_W'(fast_step_reg)) begin
                        led_time_next = now_next;
                        led_next      = base_led ^ sel_bit;
                    end
                end else begin
                    led_next = (base_led & ~sel_bit) | (profile_next & sel_bit);
                end
            end
            default: ;
        endcase
    end

    // Commit state when the word is processed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg      <= '0;
            led_time_reg <= '0;
            sel_time_reg <= '0;
            rider_reg    <= ledimc_pkg::RIDER_RST;
            sel_idx_reg  <= '0;
            profile_reg  <= '0;
            led_reg      <= '0;
            mode_reg     <= ledimc_pkg::MODE_OFF;
        end else if (advance) begin
            now_reg      <= now_next;
            led_time_reg <= led_time_next;
            sel_time_reg <= sel_time_next;
            rider_reg    <= rider_next;
            sel_idx_reg  <= sel_idx_next;
            profile_reg  <= profile_next;
            led_reg      <= led_next;
            mode_reg     <= mode_next;
        end
    end

    // Result register: load on advance, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_led_reg     <= led_next;
            out_profile_reg <= profile_next;
        end
    end

endmodule
`default_nettype wire
